// ===== hdl/prime_sieve_factor_engine_defines.svh =====
// Assertion macros used by the engine file
`ifndef PRIME_SIEVE_FACTOR_ENGINE_DEFINES_SVH
`define PRIME_SIEVE_FACTOR_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define PSF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: check failed");
`define PSF_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define PSF_ASSERT(label, clk, rst, prop)
`define PSF_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== hdl/psfe_pkg.sv =====
package psfe_pkg;
   localparam int VALUE_W = 16;
   localparam int INDEX_W = 13;
   localparam int TOTAL_W = 14;
   localparam int MAX_RESULTS = 6;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_RANGE   = 2'd1,
      STATUS_NO_FACT = 2'd2
   } status_type;

   localparam logic CMD_PRIME  = 1'b0;
   localparam logic CMD_FACTOR = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_IDLE,
      ST_PRIME_RD,
      ST_PRIME_OUT,
      ST_FACT_RD,
      ST_FACT_LOAD,
      ST_FACT_DIV,
      ST_FACT_OUT,
      ST_SINGLE_OUT
   } state_type;
endpackage

// ===== hdl/psfe_ram.sv =====
module psfe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/psfe_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module psfe_divider #(
   parameter int W = 20
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder
);
   localparam int CW = $clog2(W + 1);
   logic [W-1:0]  q_ff, q_in;
   logic [W-1:0]  r_ff, r_in;
   logic [W-1:0]  d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    trial;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         d_in    = divisor;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {r_ff, q_ff[W-1]} - {1'b0, d_ff};
         if (!trial[W]) begin
            r_in = trial[W-1:0];
            q_in = {q_ff[W-2:0], 1'b1};
         end else begin
            r_in = {r_ff[W-2:0], q_ff[W-1]};
            q_in = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;
endmodule

// ===== hdl/prime_sieve_factor_engine.sv =====
// Prime query: the prime list is read in ST_PRIME_RD and the result is registered in ST_PRIME_OUT;
//   factor query: per distinct factor, a table read and load, then e+1 divisions for multiplicity e.
// Throughput: one query at a time; set by the bit-serial divider and the table port.
// Reset: synchronous, active high. After reset the engine clears the factor table
//   and then sieves it (ST_SCAN_RD/ST_SCAN_CHK per candidate, ST_MARK_RD/ST_MARK_WR per marking step);
//   req_ready stays low until the sieve is done.
`include "prime_sieve_factor_engine_defines.svh"
module prime_sieve_factor_engine #(
   parameter int LIMIT       = 65536,
   parameter int PRIME_SLOTS = 8192
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_cmd,
   input  logic [psfe_pkg::INDEX_W-1:0] req_prime_index,
   input  logic [psfe_pkg::VALUE_W-1:0] req_number,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [psfe_pkg::VALUE_W-1:0] rsp_value,
   output logic                         rsp_last,
   output logic [1:0]                   rsp_status,
   output logic [psfe_pkg::TOTAL_W-1:0] rsp_prime_total
);
   import psfe_pkg::*;

   // table index width: enough to hold LIMIT itself so loops can end on it
   localparam int AW = $clog2(LIMIT) + 1;
   localparam int TW = $clog2(LIMIT);
   localparam int PW = $clog2(PRIME_SLOTS);
   localparam int CW = $clog2(PRIME_SLOTS + 1);
   localparam int RW = $clog2(MAX_RESULTS + 1);

   state_type state_ff, state_in;

   logic [AW-1:0] n_ff, n_in;          // sieve candidate / factor residue
   logic [AW-1:0] m_ff, m_in;          // marking pointer
   logic [AW-1:0] p_ff, p_in;          // current prime / factor
   logic [CW-1:0] count_ff, count_in;  // primes found
   logic [RW-1:0] nres_ff, nres_in;    // results given this query
   logic [PW-1:0] idx_ff, idx_in;

   logic [VALUE_W-1:0] out_value_ff, out_value_in;
   logic               out_last_ff, out_last_in;
   logic [1:0]         out_status_ff, out_status_in;
   logic               out_valid_ff, out_valid_in;

   // factor table memory (least prime factor, AW bits wide holds any value < LIMIT)
   logic          lf_we;
   logic [TW-1:0] lf_waddr, lf_raddr;
   logic [AW-1:0] lf_wdata, lf_rdata;
   // prime list memory
   logic          pl_we;
   logic [PW-1:0] pl_waddr, pl_raddr;
   logic [AW-1:0] pl_wdata, pl_rdata;

   logic          div_start, div_done;
   logic [AW-1:0] div_dividend, div_divisor;
   logic [AW-1:0] div_q, div_r;

   psfe_ram #(.WIDTH(AW), .DEPTH(LIMIT)) u_lf_ram (
      .clock(clock), .wr_en(lf_we), .wr_addr(lf_waddr), .wr_data(lf_wdata),
      .rd_addr(lf_raddr), .rd_data(lf_rdata));

   psfe_ram #(.WIDTH(AW), .DEPTH(PRIME_SLOTS)) u_pl_ram (
      .clock(clock), .wr_en(pl_we), .wr_addr(pl_waddr), .wr_data(pl_wdata),
      .rd_addr(pl_raddr), .rd_data(pl_rdata));

   psfe_divider #(.W(AW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(div_divisor), .done(div_done), .quotient(div_q), .remainder(div_r));

   logic [2*AW-1:0] sq;
   logic            req_fire, out_free;
   assign sq       = p_ff * p_ff;   // full-width square of the current prime, used when a prime is found
   assign req_fire = req_valid && req_ready;
   assign out_free = !out_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:     if (n_ff == AW'(LIMIT - 1)) state_in = ST_SCAN_RD;
         ST_SCAN_RD:   state_in = (n_ff >= AW'(LIMIT)) ? ST_IDLE : ST_SCAN_CHK;
         ST_SCAN_CHK: begin
            if (lf_rdata != '0) begin
               state_in = ST_SCAN_RD;
            end else if (sq < (2*AW)'(LIMIT)) begin
               state_in = ST_MARK_RD;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_MARK_RD:   state_in = ST_MARK_WR;
         ST_MARK_WR: begin
            if (m_ff + p_ff >= AW'(LIMIT)) state_in = ST_SCAN_RD;
            else state_in = ST_MARK_RD;
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_cmd == CMD_PRIME) begin
                  state_in = ST_PRIME_RD;
               end else if (req_number < VALUE_W'(2) ||
                            32'(req_number) >= 32'(LIMIT)) begin
                  state_in = ST_SINGLE_OUT;
               end else begin
                  state_in = ST_FACT_RD;
               end
            end
         end
         ST_PRIME_RD:  state_in = ST_PRIME_OUT;
         ST_PRIME_OUT: if (out_free) state_in = ST_IDLE;
         ST_SINGLE_OUT: if (out_free) state_in = ST_IDLE;
         ST_FACT_RD:   state_in = ST_FACT_LOAD;
         ST_FACT_LOAD: state_in = ST_FACT_DIV;
         ST_FACT_DIV: begin
            if (div_done && div_r != '0) state_in = ST_FACT_OUT;
         end
         ST_FACT_OUT: begin
            if (out_free) begin
               if (n_ff <= AW'(1) || nres_ff == RW'(MAX_RESULTS - 1)) state_in = ST_IDLE;
               else state_in = ST_FACT_RD;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      n_in          = n_ff;
      m_in          = m_ff;
      p_in          = p_ff;
      count_in      = count_ff;
      nres_in       = nres_ff;
      idx_in        = idx_ff;
      out_value_in  = out_value_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      lf_we         = 1'b0;
      lf_waddr      = n_ff[TW-1:0];
      lf_wdata      = '0;
      lf_raddr      = n_ff[TW-1:0];
      pl_we         = 1'b0;
      pl_waddr      = count_ff[PW-1:0];
      pl_wdata      = n_ff;
      pl_raddr      = idx_ff;
      div_start     = 1'b0;
      div_dividend  = n_ff;
      div_divisor   = p_ff;
      req_ready     = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            lf_we = 1'b1;
            n_in  = (n_ff == AW'(LIMIT - 1)) ? AW'(2) : n_ff + 1'b1;
         end
         ST_SCAN_RD: begin
            p_in = n_ff;
         end
         ST_SCAN_CHK: begin
            n_in = n_ff + 1'b1;
            if (lf_rdata == '0) begin
               lf_we    = 1'b1;
               lf_waddr = p_ff[TW-1:0];
               lf_wdata = p_ff;
               pl_wdata = p_ff;
               if (count_ff < CW'(PRIME_SLOTS)) begin
                  pl_we    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               m_in = sq[AW-1:0];
            end
         end
         ST_MARK_RD: begin
            lf_raddr = m_ff[TW-1:0];
         end
         ST_MARK_WR: begin
            lf_waddr = m_ff[TW-1:0];
            lf_wdata = p_ff;
            lf_we    = (lf_rdata == '0);
            m_in     = m_ff + p_ff;
         end
         ST_IDLE: begin
            req_ready = out_free;
            if (req_fire) begin
               idx_in  = PW'(req_prime_index);
               n_in    = AW'(req_number);
               nres_in = '0;
               if (req_cmd == CMD_FACTOR &&
                   (req_number < VALUE_W'(2) ||
                    32'(req_number) >= 32'(LIMIT))) begin
                  out_status_in = (req_number < VALUE_W'(2)) ? STATUS_NO_FACT : STATUS_RANGE;
               end else if (req_cmd == CMD_PRIME) begin
                  // index beyond the list or beyond the slots
                  out_status_in = (32'(req_prime_index) < 32'(count_ff) &&
                                   32'(req_prime_index) < 32'(PRIME_SLOTS))
                                  ? STATUS_OK : STATUS_RANGE;
               end
            end
         end
         ST_PRIME_OUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_last_in  = 1'b1;
               out_value_in = (out_status_ff == STATUS_OK) ? pl_rdata[VALUE_W-1:0] : '0;
            end
         end
         ST_SINGLE_OUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_last_in  = 1'b1;
               out_value_in = '0;
            end
         end
         ST_FACT_RD: begin
            lf_raddr = n_ff[TW-1:0];
         end
         ST_FACT_LOAD: begin
            // table data is valid here; latch factor, start first division
            p_in        = lf_rdata;
            div_divisor = lf_rdata;
            div_start   = 1'b1;
         end
         ST_FACT_DIV: begin
            // divide the factor out until a remainder shows up
            if (div_done && div_r == '0) begin
               n_in         = div_q;
               div_dividend = div_q;
               div_start    = 1'b1;
            end
         end
         ST_FACT_OUT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_value_in  = p_ff[VALUE_W-1:0];
               out_status_in = STATUS_OK;
               out_last_in   = (n_ff <= AW'(1)) || (nres_ff == RW'(MAX_RESULTS - 1));
               nres_in       = nres_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         n_ff         <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         nres_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         nres_ff      <= nres_in;
      end
      m_ff          <= m_in;
      p_ff          <= p_in;
      idx_ff        <= idx_in;
      out_value_ff  <= out_value_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_value       = out_value_ff;
   assign rsp_last        = out_last_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_prime_total = TOTAL_W'(count_ff);

   `PSF_ASSERT(a_no_req_while_sieve, clock, reset,
      (state_ff == ST_CLEAR || state_ff == ST_SCAN_RD) |-> !req_ready)
   `PSF_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(PRIME_SLOTS))
   `PSF_ASSERT(a_rsp_hold, clock, reset,
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_value)))
   `PSF_ASSERT(a_ok_nonzero, clock, reset,
      (rsp_valid && rsp_status == STATUS_OK) |-> (rsp_value != '0))
endmodule

// ===== bench/prime_sieve_factor_engine_checker.sv =====
module prime_sieve_factor_engine_checker
   import psfe_pkg::*;
#(
   parameter int LIMIT       = 65536,
   parameter int PRIME_SLOTS = 8192
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_cmd,
   input  logic [INDEX_W-1:0] req_prime_index,
   input  logic [VALUE_W-1:0] req_number,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [VALUE_W-1:0] rsp_value,
   input  logic               rsp_last,
   input  logic [1:0]         rsp_status,
   input  logic [TOTAL_W-1:0] rsp_prime_total,
   output int                 error_count,
   output int                 pending_count
);

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
      logic [1:0]         status;
      logic [TOTAL_W-1:0] total;
   } answer_type;

   int unsigned least_factor [LIMIT];
   int unsigned prime_at [PRIME_SLOTS];
   int unsigned num_primes;
   answer_type  answer_q [$];

   // smallest-factor table and prime list, built once up front
   initial begin
      longint unsigned m;
      num_primes = 0;
      for (int i = 0; i < LIMIT; i++) least_factor[i] = 0;
      for (int i = 0; i < PRIME_SLOTS; i++) prime_at[i] = 0;
      for (int n = 2; n < LIMIT; n++) begin
         if (least_factor[n] == 0) begin
            least_factor[n] = n;
            if (num_primes < PRIME_SLOTS) begin
               prime_at[num_primes] = n;
               num_primes++;
            end
            for (m = longint'(n) * n; m < LIMIT; m += n)
               if (least_factor[m] == 0) least_factor[m] = n;
         end
      end
   end

   function automatic answer_type make_answer(int unsigned v, bit l, status_type s);
      answer_type a;
      a.value  = v[VALUE_W-1:0];
      a.last   = l;
      a.status = s;
      a.total  = num_primes[TOTAL_W-1:0];
      return a;
   endfunction

   function automatic void add_answer(answer_type a);
      answer_q.insert(answer_q.size(), a);
   endfunction

   task automatic predict_query(logic cmd, logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] num);
      answer_type  parts [$];
      int unsigned k;
      int unsigned p;
      if (cmd == CMD_PRIME) begin
         if (idx < num_primes && idx < PRIME_SLOTS)
            add_answer(make_answer(prime_at[idx], 1'b1, STATUS_OK));
         else
            add_answer(make_answer(0, 1'b1, STATUS_RANGE));
      end else if (num < 2) begin
         add_answer(make_answer(0, 1'b1, STATUS_NO_FACT));
      end else if (num >= LIMIT) begin
         add_answer(make_answer(0, 1'b1, STATUS_RANGE));
      end else begin
         k = num;
         while (k > 1 && parts.size() < MAX_RESULTS) begin
            p = least_factor[k];
            if (p < 2) break;
            while (k % p == 0) k = k / p;
            parts.insert(parts.size(), make_answer(p, k <= 1, STATUS_OK));
         end
         if (parts.size() > 0) parts[parts.size()-1].last = 1'b1;
         foreach (parts[i]) add_answer(parts[i]);
      end
   endtask

   task automatic report(string what, int unsigned got, int unsigned want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      answer_type a;
      if (reset) begin
         error_count   = 0;
         pending_count = 0;
      end else begin
         if (req_valid && req_ready) predict_query(req_cmd, req_prime_index, req_number);
         if (rsp_valid && rsp_ready) begin
            if (answer_q.size() == 0) begin
               report("unexpected transaction", rsp_value, 0);
            end else begin
               a = answer_q.pop_front();
               if (rsp_value !== a.value) report("value", rsp_value, a.value);
               if (rsp_last !== a.last) report("last", rsp_last, a.last);
               if (rsp_status !== a.status) report("status", rsp_status, a.status);
               if (rsp_prime_total !== a.total)
                  report("prime_total", rsp_prime_total, a.total);
            end
         end
         pending_count = answer_q.size();
      end
   end

endmodule

// ===== bench/prime_sieve_factor_engine_tb.sv =====
module prime_sieve_factor_engine_tb;
   import psfe_pkg::*;

   localparam int PRIMES_BELOW_LIMIT = 6542;  // primes under 65536
   localparam int QUIET_LIMIT        = 3000000; // sieve after reset is the long pole
   localparam int DRAIN_CYCLES       = 2000;
   localparam int LONG_HOLD          = 400;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_cmd;
   logic [INDEX_W-1:0] req_prime_index;
   logic [VALUE_W-1:0] req_number;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [VALUE_W-1:0] rsp_value;
   logic               rsp_last;
   logic [1:0]         rsp_status;
   logic [TOTAL_W-1:0] rsp_prime_total;

   int error_count;
   int pending_count;
   int tx_idle_pct;
   int rx_idle_pct;
   bit hold_toggle;
   int quiet_cycles;

   prime_sieve_factor_engine i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_prime_index(req_prime_index), .req_number(req_number),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_value(rsp_value),
      .rsp_last(rsp_last), .rsp_status(rsp_status), .rsp_prime_total(rsp_prime_total)
   );

   prime_sieve_factor_engine_checker i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_prime_index(req_prime_index), .req_number(req_number),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_value(rsp_value),
      .rsp_last(rsp_last), .rsp_status(rsp_status), .rsp_prime_total(rsp_prime_total),
      .error_count(error_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: random back-pressure, plus a long hold-off whenever the
   // stimulus flips hold_toggle. The hold is counted down here.
   initial begin
      int hold_left;
      bit seen_toggle;
      hold_left   = 0;
      seen_toggle = 1'b0;
      rsp_ready   = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_toggle != seen_toggle) begin
            seen_toggle = hold_toggle;
            hold_left   = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Watchdog: any cycle with no transaction on either channel counts.
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // One query transaction. Valid is only written once per falling edge, so
   // back-to-back queries keep it high without a glitch.
   task automatic send_query(logic cmd, logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] num);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_prime_index <= idx;
      req_number      <= num;
      do @(posedge clock); while (!req_ready);
   endtask

   // Random query: mostly well-formed lookups, with products of small primes
   // to reach the deep factor chains, and plain noise in the unused field.
   task automatic random_query();
      logic [INDEX_W-1:0] idx;
      logic [VALUE_W-1:0] num;
      int unsigned        prod;
      int unsigned        pick;
      int unsigned        small_primes [8] = '{2, 3, 5, 7, 11, 13, 17, 19};
      idx  = INDEX_W'($urandom);
      num  = VALUE_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 35) begin
         if ($urandom_range(3) != 0) idx = INDEX_W'($urandom_range(PRIMES_BELOW_LIMIT - 1));
         send_query(CMD_PRIME, idx, num);
      end else if (pick < 65) begin
         send_query(CMD_FACTOR, idx, num);
      end else if (pick < 90) begin
         prod = 1;
         for (int i = 0; i < 8; i++)
            if ($urandom_range(1) && prod * small_primes[i] < 65536)
               prod = prod * small_primes[i];
         while (prod * 2 < 65536 && $urandom_range(2) == 0) prod = prod * 2;
         send_query(CMD_FACTOR, idx, prod[VALUE_W-1:0]);
      end else begin
         send_query(CMD_FACTOR, idx, VALUE_W'($urandom_range(1)));
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = CMD_PRIME;
      req_prime_index = '0;
      req_number      = '0;
      tx_idle_pct     = 15;
      rx_idle_pct     = 50;
      hold_toggle     = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: list ends, index beyond the list, zero and one,
      // primes at the top of the range, the six-factor products
      send_query(CMD_PRIME, 0, 16'hFFFF);
      send_query(CMD_PRIME, 1, 0);
      send_query(CMD_PRIME, INDEX_W'(PRIMES_BELOW_LIMIT - 1), 0);
      send_query(CMD_PRIME, INDEX_W'(PRIMES_BELOW_LIMIT), 0);
      send_query(CMD_PRIME, '1, 0);
      send_query(CMD_PRIME, 13'h1555, 16'h5555);
      send_query(CMD_FACTOR, '1, 0);
      send_query(CMD_FACTOR, 0, 1);
      send_query(CMD_FACTOR, 0, 2);
      send_query(CMD_FACTOR, 0, 3);
      send_query(CMD_FACTOR, 0, 4);
      send_query(CMD_FACTOR, 0, 16'h8000);
      send_query(CMD_FACTOR, 0, 16'hFFFF);
      send_query(CMD_FACTOR, 0, 16'd65521);
      send_query(CMD_FACTOR, 0, 16'd30030);
      send_query(CMD_FACTOR, 0, 16'd60060);
      send_query(CMD_FACTOR, 0, 16'd65535);
      send_query(CMD_FACTOR, 0, 16'hAAAA);
      send_query(CMD_FACTOR, 13'h0AAA, 16'd65519);

      repeat (130) random_query();
      tx_idle_pct = 50;
      rx_idle_pct = 15;
      repeat (130) random_query();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_toggle = ~hold_toggle;   // long receiver stall while queries keep coming
      repeat (140) random_query();

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
